FILE: rtl/char_lcd_nibble_expander_sequencer_assert.svh
// assertion macros for the lcd expander sequencer
`ifndef CHAR_LCD_NIBBLE_EXPANDER_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_EXPANDER_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CLNES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CLNES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/clnes_pkg.sv
// shared types, codes and the initialise nibble table
package clnes_pkg;

    localparam logic [3:0] CMD_BYTE    = 4'd0;
    localparam logic [3:0] CMD_DATA    = 4'd1;
    localparam logic [3:0] CMD_HALF    = 4'd2;
    localparam logic [3:0] CMD_BL_ON   = 4'd3;
    localparam logic [3:0] CMD_BL_OFF  = 4'd4;
    localparam logic [3:0] CMD_RW_LO   = 4'd5;
    localparam logic [3:0] CMD_RW_HI   = 4'd6;
    localparam logic [3:0] CMD_CURSOR  = 4'd7;
    localparam logic [3:0] CMD_INIT    = 4'd8;

    localparam logic [2:0] OP_BL_ON    = 3'd0;
    localparam logic [2:0] OP_BL_OFF   = 3'd1;
    localparam logic [2:0] OP_RW_LO    = 3'd2;
    localparam logic [2:0] OP_RW_HI    = 3'd3;
    localparam logic [2:0] OP_NIB      = 3'd4;
    localparam logic [2:0] OP_EN_HI    = 3'd5;
    localparam logic [2:0] OP_EN_LO    = 3'd6;

    localparam logic [3:0] INIT_NIB_LAST = 4'd13;

    localparam logic [7:0] EXP_ADDR_RESET = 8'h4E;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [2:0] op;
        logic       use_tab;
        logic       nib_hi;
        logic [3:0] tab_nib;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic free;
    } t_dp_stat;

    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'h8;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'hC;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'h1;
            4'd10:   nib = 4'h0;
            4'd11:   nib = 4'h6;
            4'd12:   nib = 4'h8;
            4'd13:   nib = 4'h0;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

FILE: rtl/clnes_ctrl.sv
// sequencing state machine: one expander byte per step
module clnes_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [3:0]         i_cmd,
    input  clnes_pkg::t_dp_stat i_stat,
    output clnes_pkg::t_dp_cmd  o_dp_cmd,
    output logic               o_busy
);
    import clnes_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_NIBS   = 2'd2;

    localparam logic [1:0] PH_SET    = 2'd0;
    localparam logic [1:0] PH_EN_HI  = 2'd1;
    localparam logic [1:0] PH_EN_LO  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_nib, n_nib;
    logic [3:0] r_nib_end, n_nib_end;
    logic       r_init, n_init;
    logic [2:0] r_op, n_op;
    logic       w_accept;
    logic       w_adv;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    assign w_adv    = (r_state != ST_IDLE) && i_stat.free;
    assign o_busy   = (r_state != ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_nib     = r_nib;
        n_nib_end = r_nib_end;
        n_init    = r_init;
        n_op      = r_op;

        o_dp_cmd         = '0;
        o_dp_cmd.load    = w_accept;
        o_dp_cmd.use_tab = r_init;
        o_dp_cmd.nib_hi  = (r_nib == 4'd0);
        o_dp_cmd.tab_nib = init_nibble(r_nib);

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_phase = PH_SET;
                    n_nib   = 4'd0;
                    n_init  = 1'b0;
                    case (i_cmd)
                        CMD_BYTE, CMD_DATA, CMD_CURSOR: begin
                            n_state   = ST_NIBS;
                            n_nib_end = 4'd1;
                        end
                        CMD_HALF: begin
                            n_state   = ST_NIBS;
                            n_nib_end = 4'd0;
                        end
                        CMD_BL_ON: begin
                            n_state = ST_SINGLE;
                            n_op    = OP_BL_ON;
                        end
                        CMD_BL_OFF: begin
                            n_state = ST_SINGLE;
                            n_op    = OP_BL_OFF;
                        end
                        CMD_RW_LO: begin
                            n_state = ST_SINGLE;
                            n_op    = OP_RW_LO;
                        end
                        CMD_RW_HI: begin
                            n_state = ST_SINGLE;
                            n_op    = OP_RW_HI;
                        end
                        CMD_INIT: begin
                            n_state   = ST_SINGLE;
                            n_op      = OP_RW_LO;
                            n_init    = 1'b1;
                            n_nib_end = INIT_NIB_LAST;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SINGLE: begin
                o_dp_cmd.op   = r_op;
                o_dp_cmd.last = !r_init;
                if (w_adv) begin
                    o_dp_cmd.emit = 1'b1;
                    n_state = r_init ? ST_NIBS : ST_IDLE;
                end
            end
            ST_NIBS: begin
                case (r_phase)
                    PH_SET:   o_dp_cmd.op = OP_NIB;
                    PH_EN_HI: o_dp_cmd.op = OP_EN_HI;
                    default:  o_dp_cmd.op = OP_EN_LO;
                endcase
                o_dp_cmd.last = (r_phase == PH_EN_LO) && (r_nib == r_nib_end);
                if (w_adv) begin
                    o_dp_cmd.emit = 1'b1;
                    case (r_phase)
                        PH_SET:   n_phase = PH_EN_HI;
                        PH_EN_HI: n_phase = PH_EN_LO;
                        default: begin
                            n_phase = PH_SET;
                            if (r_nib == r_nib_end) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_nib = r_nib + 4'd1;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_SET;
            r_nib     <= 4'd0;
            r_nib_end <= 4'd0;
            r_init    <= 1'b0;
            r_op      <= OP_BL_ON;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_nib     <= n_nib;
            r_nib_end <= n_nib_end;
            r_init    <= n_init;
            r_op      <= n_op;
        end
    end

endmodule

FILE: rtl/clnes_dp.sv
// expander shadow, operand latch and output register
module clnes_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clnes_pkg::t_dp_cmd  i_dp_cmd,
    output clnes_pkg::t_dp_stat o_stat,
    input  logic [3:0]         i_cmd,
    input  logic [7:0]         i_value,
    input  logic [2:0]         i_line,
    input  logic [4:0]         i_column,
    input  logic [7:0]         i_exp_addr,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_target_address,
    output logic [7:0]         o_expander_byte,
    output logic               o_last
);
    import clnes_pkg::*;

    logic [7:0] r_shadow, n_shadow;
    logic [7:0] r_operand, n_operand;
    logic       r_rs;
    logic       r_out_valid;
    logic [7:0] r_out_addr;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [7:0] w_base;
    logic [3:0] w_nib;

    assign o_stat.free      = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_target_address = r_out_addr;
    assign o_expander_byte  = r_out_byte;
    assign o_last           = r_out_last;

    // cursor address: line base plus column minus one, line out of range gives zero
    always_comb begin
        case (i_line)
            3'd1:    w_base = 8'h80;
            3'd2:    w_base = 8'hC0;
            3'd3:    w_base = 8'h94;
            3'd4:    w_base = 8'hD4;
            default: w_base = 8'h00;
        endcase
        if (i_cmd == CMD_CURSOR) begin
            n_operand = (w_base == 8'h00) ? 8'h00 : (w_base + {3'b000, i_column} - 8'd1);
        end else begin
            n_operand = i_value;
        end
    end

    assign w_nib = i_dp_cmd.use_tab ? i_dp_cmd.tab_nib :
                   (i_dp_cmd.nib_hi ? r_operand[7:4] : r_operand[3:0]);

    always_comb begin
        case (i_dp_cmd.op)
            OP_BL_ON:  n_shadow = r_shadow | 8'h08;
            OP_BL_OFF: n_shadow = r_shadow & 8'hF7;
            OP_RW_LO:  n_shadow = r_shadow & 8'hFD;
            OP_RW_HI:  n_shadow = r_shadow | 8'h02;
            OP_NIB:    n_shadow = {w_nib, r_shadow[3:1], r_rs};
            OP_EN_HI:  n_shadow = r_shadow | 8'h04;
            OP_EN_LO:  n_shadow = r_shadow & 8'hFB;
            default:   n_shadow = r_shadow;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow    <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (i_dp_cmd.emit) begin
                r_shadow    <= n_shadow;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_operand <= n_operand;
            r_rs      <= (i_cmd == CMD_DATA);
        end
        if (i_dp_cmd.emit) begin
            r_out_addr <= i_exp_addr;
            r_out_byte <= n_shadow;
            r_out_last <= i_dp_cmd.last;
        end
    end

endmodule

FILE: rtl/char_lcd_nibble_expander_sequencer.sv
// character lcd sequencer over an i2c port expander, top level
// usage:
// input channel i_in_valid / o_in_stall carries cmd, value, line and column.
// output channel o_out_valid / i_out_stall carries one expander byte per
// transfer, tagged with the expander's i2c address and a last flag on the
// final byte of each command's run.
// an accepted command gives 1, 3, 6 or 43 output transfers (none for
// unused codes); the first byte is registered once the controller has
// left idle, then one byte per cycle while the receiver takes them.
// the controller produces one byte per cycle, while the output is not
// stalled, into a single output register. o_in_stall is high until the
// controller has handed the last byte to the output register, so the
// next command can be taken while that byte still waits.
// a stall on the output holds the byte and pauses the sequence.
// reset clears the expander shadow to zero, sets the address register to
// 0x4E and empties the output register.
// apb register 0 at byte address 0: expander i2c write address.
module char_lcd_nibble_expander_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_cmd,
    input  logic [7:0] i_value,
    input  logic [2:0] i_line,
    input  logic [4:0] i_column,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_target_address,
    output logic [7:0] o_expander_byte,
    output logic       o_last
);
    import clnes_pkg::*;

    `include "char_lcd_nibble_expander_sequencer_assert.svh"

    logic [7:0] r_exp_addr;
    logic       w_busy;
    logic       w_reg0;
    t_dp_cmd    w_dp_cmd;
    t_dp_stat   w_stat;

    assign pready     = 1'b1;
    assign w_reg0     = (paddr[2] == 1'b0);
    assign prdata     = w_reg0 ? {24'h000000, r_exp_addr} : 32'h00000000;
    assign o_in_stall = w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr <= EXP_ADDR_RESET;
        end else if (psel && penable && pwrite && pready && w_reg0) begin
            r_exp_addr <= pwdata[7:0];
        end
    end

    clnes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (w_stat),
        .o_dp_cmd   (w_dp_cmd),
        .o_busy     (w_busy)
    );

    clnes_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (w_dp_cmd),
        .o_stat           (w_stat),
        .i_cmd            (i_cmd),
        .i_value          (i_value),
        .i_line           (i_line),
        .i_column         (i_column),
        .i_exp_addr       (r_exp_addr),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_target_address (o_target_address),
        .o_expander_byte  (o_expander_byte),
        .o_last           (o_last)
    );

    `CLNES_ASSERT_NOW(a_no_overwrite, w_dp_cmd.emit, !o_out_valid || !i_out_stall, "output overwritten while stalled")
    `CLNES_ASSERT_NOW(a_last_en_low, o_out_valid && o_last, !o_expander_byte[2], "run ends with enable high")
    `CLNES_ASSERT_NEXT(a_unused_idle, i_in_valid && !o_in_stall && (i_cmd > CMD_INIT), !w_busy, "unused code started a run")
    `CLNES_ASSERT_NEXT(a_single_busy, i_in_valid && !o_in_stall && (i_cmd == CMD_BL_ON || i_cmd == CMD_RW_HI), w_busy, "command dropped")

endmodule
